FILE: rtl/bba_pkg.sv
// Package for the bitmap block allocator: default sizes, operation and
// command codes, request/response payloads and the front-to-back command.
// No dependencies.
package bba_pkg;

  localparam int NUM_BLOCKS_DEF  = 32768;
  localparam int WORD_BITS_DEF   = 32;   // power of two, 8..64
  localparam int BLOCK_BYTES_DEF = 4096; // power of two, 512..65536

  // Block positions in a command; covers the largest supported map (2^20 blocks).
  localparam int POS_W = 21;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_RESERVE = 2'd3;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_SET   = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [31:0] length;
  } bba_req_t;

  typedef struct packed {
    logic [31:0] block_address;
    logic        success;
    logic [15:0] free_blocks;
  } bba_rsp_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             fix0;   // re-mark block 0 used afterwards
    logic             empty;  // clipped range holds no block
    logic [POS_W-1:0] lo;     // first block
    logic [POS_W-1:0] hi;     // one past last block
  } bba_cmd_t;

endpackage

FILE: rtl/bitmap_block_allocator_core.sv
// Bitmap block allocator, top level: front end with command queue, back end
// with bitmap memory and counter. Depends on bba_pkg, bba_front, bba_back.
// Allocate scans bitmap words from word 0 until one holds a free bit; range ops (free,
// release, reserve) read and write each bitmap word touched, and release then re-marks
// block 0 used; a failed allocate or an empty range (release apart) answers directly.
// One item in the back end at a time, held while an older response waits; the next
// starts the cycle after the response is loaded, and the queue takes two more meanwhile.
// Reset: synchronous; then a clearing pass over all MAP_WORDS bitmap words (1024 by
// default) sets every block used, with req_ready low throughout.
module bitmap_block_allocator_core #(
  parameter int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BITS   = bba_pkg::WORD_BITS_DEF,
  parameter int BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  bba_pkg::bba_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output bba_pkg::bba_rsp_t rsp
);
  import bba_pkg::*;

  bba_cmd_t cmd;
  logic     cmd_valid;
  logic     cmd_ready;
  logic     enable;

  bba_front #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .enable    (enable),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  bba_back #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .WORD_BITS   (WORD_BITS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .enable    (enable),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

FILE: rtl/bba_front.sv
// Front end: takes request transfers, turns each into a clipped block range
// command and holds it in a two-entry queue for the back end.
// Depends on bba_pkg.
module bba_front #(
  parameter int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              enable,
  input  logic              req_valid,
  output logic              req_ready,
  input  bba_pkg::bba_req_t req,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output bba_pkg::bba_cmd_t cmd
);
  import bba_pkg::*;

  localparam int BB_LOG = $clog2(BLOCK_BYTES);

  logic [33:0] first;
  logic [33:0] nblk;
  logic [33:0] n;
  logic [33:0] last;
  logic [33:0] hi_c;
  logic        rnd;
  bba_cmd_t    cmd_in;

  bba_cmd_t    ent [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  fill;
  logic        push;
  logic        pop;

  always_comb begin
    first = 34'(req.address >> BB_LOG);
    nblk  = 34'(req.length >> BB_LOG);
    rnd   = |(req.length & 32'(BLOCK_BYTES - 1));
    unique case (req.operation)
      OP_FREE:    n = 34'd1;
      OP_RESERVE: n = nblk + 34'(rnd);
      default:    n = nblk;
    endcase
    last = first + n;
    hi_c = (last > 34'(NUM_BLOCKS)) ? 34'(NUM_BLOCKS) : last;

    cmd_in.empty = (first >= 34'(NUM_BLOCKS)) || (hi_c <= first);
    cmd_in.lo    = POS_W'(first);
    cmd_in.hi    = POS_W'(hi_c);
    cmd_in.fix0  = (req.operation == OP_RELEASE);
    unique case (req.operation)
      OP_ALLOC:             cmd_in.kind = KIND_ALLOC;
      OP_FREE, OP_RELEASE:  cmd_in.kind = KIND_CLEAR;
      default:              cmd_in.kind = KIND_SET;
    endcase
  end

  assign req_ready = enable && (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = ent[rptr];
  assign push      = req_valid && req_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/bba_back.sv
// Back end: usage bitmap memory, free-block counter, first-fit scan, range
// walker and the response register.
// Depends on bba_pkg.
module bba_back #(
  parameter int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BITS   = bba_pkg::WORD_BITS_DEF,
  parameter int BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  output logic              enable,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  bba_pkg::bba_cmd_t cmd,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output bba_pkg::bba_rsp_t rsp
);
  import bba_pkg::*;

  localparam int WB_LOG    = $clog2(WORD_BITS);
  localparam int BB_LOG    = $clog2(BLOCK_BYTES);
  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IDX_W     = WIDX_W + WB_LOG;
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int NBYTE     = WORD_BITS / 8;
  localparam int SUM_W     = WB_LOG + 1;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic [WIDX_W-1:0]    rd_addr;
  logic [WIDX_W-1:0]    wa;
  logic [WORD_BITS-1:0] wd;
  logic                 we;

  logic [2:0]           state;
  logic [WIDX_W-1:0]    init_ptr;
  logic [WIDX_W-1:0]    cur_w;
  logic [WIDX_W-1:0]    last_w;
  logic [WIDX_W-1:0]    scan_ptr;
  logic [WIDX_W-1:0]    scan_w;
  logic                 scan_vld;
  logic [POS_W-1:0]     lo;
  logic [POS_W-1:0]     hi;
  logic                 set_mode;
  logic                 fix0;
  logic [CNT_W-1:0]     count;
  logic [3:0]           bcnt [NBYTE];
  logic                 cpend;
  logic                 cdec;
  logic [31:0]          res_addr;
  logic                 res_ok;

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] rng_new;
  logic [WORD_BITS-1:0] rng_chg;
  logic [WORD_BITS-1:0] alloc_bit;
  logic [WORD_BITS-1:0] chg;
  logic [WB_LOG-1:0]    free_bit;
  logic [IDX_W+31:0]    alloc_ext;
  logic                 zero_hit;
  logic [3:0]           bc [NBYTE];
  logic [SUM_W-1:0]     bsum;

  assign enable    = (state != ST_INIT);
  assign cmd_ready = (state == ST_IDLE);
  assign zero_hit  = scan_vld && (rdata != '1);

  always_comb begin
    logic [POS_W-1:0] pos;
    for (int j = 0; j < WORD_BITS; j++) begin
      pos     = POS_W'({cur_w, WB_LOG'(j)});
      mask[j] = (pos >= lo) && (pos < hi);
    end
    rng_new = set_mode ? (rdata | mask) : (rdata & ~mask);
    rng_chg = set_mode ? (mask & ~rdata) : (mask & rdata);

    free_bit = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (!rdata[j]) begin
        free_bit = WB_LOG'(j);
      end
    end
    alloc_bit = WORD_BITS'(1) << free_bit;
    alloc_ext = (IDX_W + 32)'({scan_w, free_bit}) << BB_LOG;
    chg       = (state == ST_WR) ? rng_chg : alloc_bit;
  end

  always_comb begin
    for (int b = 0; b < NBYTE; b++) begin
      bc[b] = 4'd0;
      for (int k = 0; k < 8; k++) begin
        bc[b] = bc[b] + 4'(chg[8*b + k]);
      end
    end
    bsum = '0;
    for (int b = 0; b < NBYTE; b++) begin
      bsum = bsum + SUM_W'(bcnt[b]);
    end
  end

  always_comb begin
    rd_addr = (state == ST_SCAN) ? scan_ptr : cur_w;
    we      = 1'b0;
    wa      = cur_w;
    wd      = rng_new;
    unique case (state)
      ST_INIT: begin
        we = 1'b1;
        wa = init_ptr;
        wd = '1;
      end
      ST_WR: begin
        we = 1'b1;
      end
      ST_SCAN: begin
        we = zero_hit;
        wa = scan_w;
        wd = rdata | alloc_bit;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      init_ptr  <= '0;
      cpend     <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
      scan_vld  <= 1'b0;
    end else begin
      cpend <= 1'b0;
      if (cpend) begin
        count <= cdec ? count - CNT_W'(bsum) : count + CNT_W'(bsum);
      end
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        ST_INIT: begin
          init_ptr <= init_ptr + 1'b1;
          if (init_ptr == WIDX_W'(MAP_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            res_addr <= '0;
            res_ok   <= 1'b1;
            set_mode <= (cmd.kind == KIND_SET);
            fix0     <= cmd.fix0;
            lo       <= cmd.lo;
            hi       <= cmd.hi;
            cur_w    <= WIDX_W'(cmd.lo >> WB_LOG);
            last_w   <= WIDX_W'((cmd.hi - 1'b1) >> WB_LOG);
            case (cmd.kind)
              KIND_ALLOC: begin
                if (count == '0) begin
                  res_ok <= 1'b0;
                  state  <= ST_FIN;
                end else begin
                  scan_ptr <= '0;
                  scan_vld <= 1'b0;
                  state    <= ST_SCAN;
                end
              end
              KIND_CLEAR, KIND_SET: begin
                if (!cmd.empty) begin
                  state <= ST_RD;
                end else if (cmd.fix0) begin
                  // nothing to release: go straight to keeping block 0 used
                  lo       <= '0;
                  hi       <= POS_W'(1);
                  set_mode <= 1'b1;
                  fix0     <= 1'b0;
                  cur_w    <= '0;
                  last_w   <= '0;
                  state    <= ST_RD;
                end else begin
                  state <= ST_FIN;
                end
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_SCAN: begin
          scan_ptr <= scan_ptr + 1'b1;
          scan_w   <= scan_ptr;
          scan_vld <= 1'b1;
          if (zero_hit) begin
            bcnt     <= bc;
            cpend    <= 1'b1;
            cdec     <= 1'b1;
            res_addr <= alloc_ext[31:0];
            scan_vld <= 1'b0;
            state    <= ST_FIN;
          end
        end
        ST_RD: begin
          state <= ST_WR;
        end
        ST_WR: begin
          bcnt  <= bc;
          cpend <= 1'b1;
          cdec  <= set_mode;
          if (cur_w != last_w) begin
            cur_w <= cur_w + 1'b1;
            state <= ST_RD;
          end else if (fix0) begin
            lo       <= '0;
            hi       <= POS_W'(1);
            set_mode <= 1'b1;
            fix0     <= 1'b0;
            cur_w    <= '0;
            last_w   <= '0;
            state    <= ST_RD;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!cpend && (!rsp_valid || rsp_ready)) begin
            rsp_valid         <= 1'b1;
            rsp.block_address <= res_addr;
            rsp.success       <= res_ok;
            rsp.free_blocks   <= 16'(count);
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/bba_chk.sv
// Port-level checker for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator_core.
module bba_chk (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input bba_pkg::bba_req_t req,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input bba_pkg::bba_rsp_t rsp
);
  import bba_pkg::*;

  logic [2:0] pend;
  logic       req_xfer;
  logic       rsp_xfer;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (req_xfer && !rsp_xfer) begin
      pend <= pend + 3'd1;
    end else if (rsp_xfer && !req_xfer) begin
      pend <= pend - 3'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_init_block: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("request taken during bitmap clearing");

  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.success |-> rsp.block_address == 32'd0 && rsp.free_blocks == 16'd0)
    else $error("failed allocation with free blocks or nonzero address");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pend != 3'd0)
    else $error("response without an outstanding request");

endmodule

bind bitmap_block_allocator_core bba_chk u_chk (.*);

FILE: tb/sv/tb_top.sv
// Testbench for bitmap_block_allocator_core: directed and random allocate, free,
// release and reserve requests, each response checked against an in-bench model.
// Depends on bba_pkg and the allocator RTL.
module tb_top;
  import bba_pkg::*;

  localparam int NB        = NUM_BLOCKS_DEF;
  localparam int WB        = WORD_BITS_DEF;
  localparam int BB        = BLOCK_BYTES_DEF;
  localparam int MAP_WORDS = (NB + WB - 1) / WB;
  localparam int RAND_OPS  = 1950;
  localparam logic [31:0] LAST_ADDR = 32'((NB - 1) * BB);

  typedef struct {
    bba_req_t item;
    bit       hold_idle;
  } queued_req_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  bba_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  bba_rsp_t rsp;

  queued_req_t     send_queue[$];
  queued_req_t     next_req;
  bba_rsp_t        awaited_rsps[$];
  int              outstanding = 0;
  int              mismatches = 0;
  int              rsp_seen = 0;
  longint unsigned cycle_budget = 0;
  longint unsigned cycles = 0;

  bit [WB-1:0]     used_words [MAP_WORDS];
  int unsigned     free_total;

  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  bitmap_block_allocator_core #(
    .NUM_BLOCKS (NB),
    .WORD_BITS  (WB),
    .BLOCK_BYTES(BB)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #5 clk = ~clk;

  function automatic void mark_block(longint unsigned blk, bit make_used);
    int unsigned w;
    int unsigned j;
    if (blk >= NB) return;
    w = blk / WB;
    j = blk % WB;
    if (used_words[w][j] != make_used) begin
      used_words[w][j] = make_used;
      if (make_used) free_total--;
      else free_total++;
    end
  endfunction

  function automatic bba_rsp_t allocator_step(bba_req_t r);
    bba_rsp_t        res;
    longint unsigned first;
    longint unsigned cnt;
    longint unsigned stop;
    longint unsigned b;
    longint unsigned blk;
    bit              found;
    res.block_address = '0;
    res.success = 1'b1;
    first = r.address / BB;
    found = 1'b0;
    blk = 0;
    case (r.operation)
      OP_ALLOC: begin
        if (free_total != 0) begin
          for (int w = 0; w < MAP_WORDS && !found; w++) begin
            if (used_words[w] != '1) begin
              for (int j = 0; j < WB; j++) begin
                if (!found && !used_words[w][j] && w * WB + j < NB) begin
                  found = 1'b1;
                  blk = w * WB + j;
                end
              end
            end
          end
        end
        if (found) begin
          mark_block(blk, 1'b1);
          res.block_address = 32'(blk * BB);
        end else begin
          res.success = 1'b0;
        end
      end
      OP_FREE: mark_block(first, 1'b0);
      OP_RELEASE: begin
        cnt = r.length / BB;
        stop = (first + cnt > NB) ? NB : first + cnt;
        for (b = first; b < stop; b++) mark_block(b, 1'b0);
        mark_block(0, 1'b1);
      end
      default: begin
        cnt = r.length / BB + ((r.length % BB != 0) ? 1 : 0);
        stop = (first + cnt > NB) ? NB : first + cnt;
        for (b = first; b < stop; b++) mark_block(b, 1'b1);
      end
    endcase
    res.free_blocks = 16'(free_total);
    return res;
  endfunction

  // queue one request and add its worst-case service time to the run budget
  function automatic void queue_op(logic [1:0] op, logic [31:0] addr, logic [31:0] len,
                                   bit hold);
    queued_req_t     q;
    longint unsigned first;
    longint unsigned cnt;
    longint unsigned stop;
    longint unsigned work;
    q.item.operation = op;
    q.item.address = addr;
    q.item.length = len;
    q.hold_idle = hold;
    first = addr / BB;
    cnt = len / BB + ((op == OP_RESERVE && len % BB != 0) ? 1 : 0);
    stop = (first + cnt > NB) ? NB : first + cnt;
    case (op)
      OP_ALLOC: work = MAP_WORDS;
      OP_FREE:  work = 0;
      default:  work = (first < stop) ? 2 * ((stop - 1) / WB - first / WB + 1) : 0;
    endcase
    cycle_budget += work + 100;
    send_queue.push_back(q);
  endfunction

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (gap_left > 0 || send_queue.size() == 0 ||
          (send_queue[0].hold_idle && (req_valid || outstanding != 0))) begin
        req_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        next_req = send_queue.pop_front();
        req_valid <= 1'b1;
        req <= next_req.item;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 31);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // response stall pattern, switching between modes
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (stall_mode)
        0: rsp_ready <= 1'b1;
        1: rsp_ready <= 1'($urandom_range(0, 1));
        2: rsp_ready <= ($urandom_range(0, 3) == 0);
        default: rsp_ready <= (cycles % 13) < 2;
      endcase
    end
  end

  // monitor: predict on each request transfer, check each response transfer
  always @(posedge clk) begin
    bba_rsp_t want;
    if (rst) begin
      foreach (used_words[i]) used_words[i] = '1;
      free_total = 0;
      outstanding <= 0;
    end else begin
      if (req_valid && req_ready) awaited_rsps.push_back(allocator_step(req));
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsps.size() == 0) begin
          if (mismatches < 10)
            $display("response %0d with none expected: addr=%h success=%b free=%0d",
                     rsp_seen, rsp.block_address, rsp.success, rsp.free_blocks);
          mismatches++;
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp.block_address !== want.block_address || rsp.success !== want.success ||
              rsp.free_blocks !== want.free_blocks) begin
            if (mismatches < 10)
              $display("response %0d: exp addr=%h success=%b free=%0d, got addr=%h success=%b free=%0d",
                       rsp_seen, want.block_address, want.success, want.free_blocks,
                       rsp.block_address, rsp.success, rsp.free_blocks);
            mismatches++;
          end
        end
        rsp_seen++;
      end
      outstanding <= awaited_rsps.size();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3 * cycle_budget + MAP_WORDS + 5000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int          sel;
    int          pick;
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] len;

    queue_op(OP_ALLOC,   32'h0, 32'h0, 1'b0);
    queue_op(OP_FREE,    32'hFFFF_FFFF, 32'h0, 1'b0);
    queue_op(OP_RESERVE, 32'h0, 32'h0, 1'b0);
    queue_op(OP_RELEASE, 32'h0, 32'hFFFF_FFFF, 1'b0);
    queue_op(OP_FREE,    32'h0, 32'h0, 1'b0);
    queue_op(OP_FREE,    32'(BB + 5), 32'h0, 1'b0);
    queue_op(OP_ALLOC,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_op(OP_ALLOC,   32'h0, 32'h0, 1'b0);
    queue_op(OP_RESERVE, 32'h0, 32'h1, 1'b0);
    queue_op(OP_RESERVE, LAST_ADDR, 32'hFFFF_FFFF, 1'b0);
    queue_op(OP_RESERVE, 32'h0, 32'hFFFF_FFFF, 1'b0);
    queue_op(OP_ALLOC,   32'h0, 32'h0, 1'b1);
    queue_op(OP_RELEASE, 32'(5 * BB), 32'(2 * BB - 1), 1'b0);
    queue_op(OP_RELEASE, 32'h0, 32'(3 * BB), 1'b0);
    queue_op(OP_RELEASE, 32'(NB * BB), 32'(16 * BB), 1'b0);
    queue_op(OP_RELEASE, LAST_ADDR, 32'hFFFF_FFFF, 1'b0);
    queue_op(OP_ALLOC,   32'h0, 32'h0, 1'b0);
    queue_op(OP_FREE,    32'hFFFF_F000, 32'h0, 1'b0);
    queue_op(OP_RESERVE, 32'(2 * BB + 1), 32'(BB - 1), 1'b0);
    queue_op(OP_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_op(OP_FREE,    32'h0, 32'h0, 1'b0);
    queue_op(OP_RELEASE, 32'(16 * BB), 32'h0, 1'b0);
    queue_op(OP_RESERVE, 32'h0, 32'hFFFF_FFFF, 1'b0);
    queue_op(OP_RELEASE, 32'((NB - 2) * BB), 32'(2 * BB), 1'b0);
    queue_op(OP_ALLOC,   32'h0, 32'h0, 1'b1);

    // mostly low blocks and short ranges; a few map-wide or out-of-map requests
    for (int i = 0; i < RAND_OPS; i++) begin
      sel = $urandom_range(0, 99);
      op = (sel < 35) ? OP_ALLOC : (sel < 60) ? OP_FREE : (sel < 80) ? OP_RELEASE : OP_RESERVE;
      pick = $urandom_range(0, 99);
      if (pick < 70) addr = $urandom_range(0, 511) * BB + $urandom_range(0, BB - 1);
      else if (pick < 90) addr = $urandom_range(0, NB - 1) * BB + $urandom_range(0, BB - 1);
      else addr = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 85) len = $urandom_range(0, 16 * BB);
      else if (pick < 95) len = $urandom_range(0, 512 * BB);
      else len = $urandom;
      queue_op(op, addr, len, (i % 250 == 249) || ($urandom_range(0, 99) == 0));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk); while (send_queue.size() != 0 || req_valid || outstanding != 0);
    repeat (200) @(negedge clk);
    if (mismatches == 0 && awaited_rsps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
